// ===== sv/msbg_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package msbg_pkg;

    // default payload frame limit in encoded bytes
    localparam int MAX_FRAME_BYTES_DEF = 64;

    // data bytes per group before a mask byte
    localparam int GROUP_SIZE = 7;
    localparam int POS_W      = 3;
    localparam int COLL_W     = 7;

    localparam logic [7:0] START_MARK = 8'h80;
    localparam logic [7:0] LOW_MASK   = 8'h7F;

    // queue depth and its count width
    localparam int QUEUE_DEPTH = 2;
    localparam int QCNT_W      = 2;

    // one encoded output word
    typedef struct packed {
        logic [7:0] data;
        logic       last;
        logic       too_long;
    } word_t;

    // words handed from the encoder to the output queue at once
    typedef struct packed {
        logic [QCNT_W-1:0] cnt;
        word_t             w0;
        word_t             w1;
    } push_t;

endpackage

`default_nettype wire

// ===== sv/msbg_core.sv =====
`timescale 1ns / 1ps
`default_nettype none

module msbg_core
    import msbg_pkg::*;
#(
    parameter int MAX_FRAME_BYTES = MAX_FRAME_BYTES_DEF
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_stall,
    input  logic [7:0]        data_byte,
    input  logic              is_last,
    input  logic [QCNT_W-1:0] free_slots,
    output push_t             push
);

    localparam int LEN_LIMIT = (MAX_FRAME_BYTES * 7) / 8 - 1;
    localparam int CNT_W     = $clog2(LEN_LIMIT + 1);

    // input register
    logic             in_vld_reg, in_vld_next;
    logic [7:0]       data_reg;
    logic             last_reg;

    // frame state
    logic [POS_W-1:0]  pos_reg, pos_next, pos_upd;
    logic [COLL_W-1:0] coll_reg, coll_next, coll_upd, coll_hit;
    logic [CNT_W-1:0]  cnt_reg, cnt_next, cnt_upd;
    logic              drop_reg, drop_next, drop_upd;

    logic [QCNT_W-1:0] res_n;
    word_t             w0, w1;
    logic              consume;
    logic              accept;

    function automatic logic [7:0] data_byte_mark(input logic [7:0] d);
        return d | START_MARK;
    endfunction

    always_comb
    begin
        res_n    = '0;
        w0       = '0;
        w1       = '0;
        pos_upd  = pos_reg;
        coll_upd = coll_reg;
        cnt_upd  = cnt_reg;
        drop_upd = drop_reg;
        coll_hit = data_reg[7] ? (COLL_W'(1) << pos_reg) : '0;

        if (drop_reg)
        begin
            // skip the tail of an over-long payload
            if (last_reg)
            begin
                drop_upd = 1'b0;
                pos_upd  = '0;
                coll_upd = '0;
                cnt_upd  = '0;
            end
        end
        else if (cnt_reg == '0 && last_reg)
        begin
            // single-byte payload: byte with start mark, no mask byte
            res_n       = QCNT_W'(1);
            w0.data     = data_byte_mark(data_reg);
            w0.last     = 1'b1;
            pos_upd     = '0;
            coll_upd    = '0;
            cnt_upd     = '0;
        end
        else if (cnt_reg == CNT_W'(LEN_LIMIT))
        begin
            // length error word, then drop unless this byte ends the payload
            res_n       = QCNT_W'(1);
            w0.last     = 1'b1;
            w0.too_long = 1'b1;
            pos_upd     = '0;
            coll_upd    = '0;
            cnt_upd     = '0;
            drop_upd    = !last_reg;
        end
        else
        begin
            res_n    = QCNT_W'(1);
            cnt_upd  = cnt_reg + CNT_W'(1);
            coll_upd = coll_reg | coll_hit;
            pos_upd  = pos_reg + POS_W'(1);
            w0.data  = (data_reg & LOW_MASK) | ((cnt_reg == '0) ? START_MARK : 8'h00);
            if (pos_reg == POS_W'(GROUP_SIZE - 1) || last_reg)
            begin
                // group closes: mask byte follows
                res_n    = QCNT_W'(2);
                w1.data  = {1'b0, coll_upd};
                w1.last  = last_reg;
                pos_upd  = '0;
                coll_upd = '0;
                if (last_reg)
                begin
                    cnt_upd = '0;
                end
            end
        end
    end

    assign consume  = in_vld_reg && (res_n <= free_slots);
    assign in_stall = in_vld_reg && !consume;
    assign accept   = in_valid && !in_stall;

    always_comb
    begin
        pos_next    = consume ? pos_upd  : pos_reg;
        coll_next   = consume ? coll_upd : coll_reg;
        cnt_next    = consume ? cnt_upd  : cnt_reg;
        drop_next   = consume ? drop_upd : drop_reg;
        in_vld_next = accept ? 1'b1 : (consume ? 1'b0 : in_vld_reg);
    end

    always_comb
    begin
        push     = '0;
        push.w0  = w0;
        push.w1  = w1;
        push.cnt = consume ? res_n : '0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_vld_reg <= 1'b0;
            pos_reg    <= '0;
            coll_reg   <= '0;
            cnt_reg    <= '0;
            drop_reg   <= 1'b0;
        end
        else
        begin
            in_vld_reg <= in_vld_next;
            pos_reg    <= pos_next;
            coll_reg   <= coll_next;
            cnt_reg    <= cnt_next;
            drop_reg   <= drop_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            data_reg <= data_byte;
            last_reg <= is_last;
        end
    end

    a_drop_silent: assert property (@(posedge clk) disable iff (!rst_n)
        drop_reg && consume |-> push.cnt == '0)
        else $error("word produced while dropping");

    a_err_alone: assert property (@(posedge clk) disable iff (!rst_n)
        push.cnt != '0 && push.w0.too_long |-> push.w0.last && push.cnt == QCNT_W'(1))
        else $error("length error word not alone or not last");

    a_pos_range: assert property (@(posedge clk) disable iff (!rst_n)
        pos_reg <= POS_W'(GROUP_SIZE - 1))
        else $error("group position out of range");

endmodule

`default_nettype wire

// ===== sv/msbg_out_queue.sv =====
`timescale 1ns / 1ps
`default_nettype none

module msbg_out_queue
    import msbg_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  push_t             push,
    output logic [QCNT_W-1:0] free_slots,
    output logic              out_valid,
    input  logic              out_stall,
    output logic [7:0]        out_byte,
    output logic              out_last,
    output logic              too_long
);

    word_t             q_reg  [QUEUE_DEPTH];
    word_t             q_next [QUEUE_DEPTH];
    logic [QCNT_W-1:0] count_reg, count_next;
    logic [QCNT_W-1:0] rem;
    logic              pop;

    assign out_valid  = count_reg != '0;
    assign pop        = out_valid && !out_stall;
    assign rem        = count_reg - QCNT_W'(pop);
    assign free_slots = QCNT_W'(QUEUE_DEPTH) - rem;

    always_comb
    begin
        q_next = q_reg;
        if (pop)
        begin
            q_next[0] = q_reg[1];
        end
        if (push.cnt != '0)
        begin
            q_next[rem[0]] = push.w0;
        end
        if (push.cnt == QCNT_W'(2))
        begin
            q_next[1] = push.w1;
        end
        count_next = rem + push.cnt;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
        end
        else
        begin
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        q_reg <= q_next;
    end

    assign out_byte = q_reg[0].data;
    assign out_last = q_reg[0].last;
    assign too_long = q_reg[0].too_long;

    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= QCNT_W'(QUEUE_DEPTH))
        else $error("queue count out of range");

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        push.cnt <= free_slots)
        else $error("push exceeds free slots");

    a_drain: assert property (@(posedge clk) disable iff (!rst_n)
        pop && count_reg == QCNT_W'(1) && push.cnt == '0 |=> count_reg == '0)
        else $error("queue failed to drain");

endmodule

`default_nettype wire

// ===== sv/seven_bit_msb_group_encoder_unit.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Seven-bit MSB group encoder. Each payload byte goes out with bit 7 cleared;
// the cleared top bits of up to seven bytes are packed into a mask byte that
// follows the group (bit j = top bit of the j-th byte). The first word of a
// frame carries bit 7 set as the start mark, and a one-byte payload is sent
// as that byte with bit 7 set and no mask. A payload longer than
// (MAX_FRAME_BYTES*7)/8 - 1 bytes yields one word with too_long and out_last
// set, and the rest of that payload up to its last flag is dropped silently.
// The single output port moves one word per cycle while out_stall is low, so
// a byte followed by a mask byte (it closes a group of seven or ends a
// payload of two or more bytes) needs two free queue slots, and the input
// stalls until they are free (seven input words give eight output words).
// Words pass an input register, then a two-word output queue that can still
// take one word while a finished word waits on out_stall.

module seven_bit_msb_group_encoder_unit
    import msbg_pkg::*;
#(
    parameter int MAX_FRAME_BYTES = MAX_FRAME_BYTES_DEF
)
(
    input  logic       clk,
    input  logic       rst_n,

    // input words
    input  logic       in_valid,
    output logic       in_stall,
    input  logic [7:0] data_byte,
    input  logic       is_last,

    // output words
    output logic       out_valid,
    input  logic       out_stall,
    output logic [7:0] out_byte,
    output logic       out_last,
    output logic       too_long
);

    push_t             push;
    logic [QCNT_W-1:0] free_slots;

    // input register, frame state and encode logic
    msbg_core #(
        .MAX_FRAME_BYTES (MAX_FRAME_BYTES)
    ) u_core (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .data_byte  (data_byte),
        .is_last    (is_last),
        .free_slots (free_slots),
        .push       (push)
    );

    // two-word result queue; takes a data word plus its mask word at once
    msbg_out_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .free_slots (free_slots),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .out_byte   (out_byte),
        .out_last   (out_last),
        .too_long   (too_long)
    );

endmodule

`default_nettype wire
